// ----- src/ddrbc_pkg.sv -----
// Shared constants, codes and small functions for the differential-drive ramp/brake controller.
// Depends on nothing; the controller top level imports it.
`default_nettype none

package ddrbc_pkg;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Field widths.
    localparam int GEAR_W  = 2;
    localparam int ANGLE_W = 8;
    localparam int POWER_W = 7;
    localparam int ECHO_W  = 15;
    localparam int DUTY_W  = 8;
    localparam int MODE_W  = 2;
    localparam int DIST_W  = 17;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int STOP_W      = 9;
    localparam int STEP_W      = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_STOP_DISTANCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_STEP    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_STEP    = 2'd2;

    localparam logic [STOP_W-1:0] STOP_RESET  = 9'd20;
    localparam logic [STEP_W-1:0] ACCEL_RESET = 8'd5;
    localparam logic [STEP_W-1:0] BRAKE_RESET = 8'd10;

    // Gear codes.
    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 2'd0;
    localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 2'd1;
    localparam logic [GEAR_W-1:0] GEAR_SPORT   = 2'd2;
    localparam logic [GEAR_W-1:0] GEAR_REVERSE = 2'd3;

    // H-bridge modes.
    localparam logic [MODE_W-1:0] MODE_COAST   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORWARD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BRAKE   = 2'd3;

    // Echo handling.
    localparam logic [ECHO_W-1:0] ECHO_LIMIT_US    = 15'd25000;
    localparam logic [DIST_W-1:0] TIMEOUT_CENTI_CM = 17'd99900;
    localparam logic [STOP_W:0]   TIMEOUT_CM       = 10'd999;

    // Reciprocal for echo/10: exact for every 15-bit echo value.
    localparam int QUOT_W      = 12;
    localparam int DIV10_SHIFT = 18;
    localparam logic [ECHO_W-1:0] DIV10_MUL = 15'd26215;

    // Steering scale (90 - |angle|) / 90.
    localparam int MAG_W     = 7;
    localparam int ANGLE_MAX = 90;

    // Integer part of 17*r/10 for a remainder r of 0..9.
    function automatic logic [3:0] dist_frac(input logic [3:0] r);
        logic [3:0] f;
        unique case (r)
            4'd0:    f = 4'd0;
            4'd1:    f = 4'd1;
            4'd2:    f = 4'd3;
            4'd3:    f = 4'd5;
            4'd4:    f = 4'd6;
            4'd5:    f = 4'd8;
            4'd6:    f = 4'd10;
            4'd7:    f = 4'd11;
            4'd8:    f = 4'd13;
            4'd9:    f = 4'd15;
            default: f = 4'd0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- src/diff_drive_ramp_brake_controller_unit.sv -----
// Differential-drive motor controller with power ramp and ultrasonic obstacle brake.
// Three-stage stream pipeline; uses ddrbc_pkg for codes, widths and the distance table.
// An accepted item reaches m_tvalid through the stage 1, stage 2 and output registers.
// Throughput: one item per cycle while m_tready is high; the ramp register closes its loop
// in the middle stage. Config is always ready; new ramp steps also act on accepted items.
// Reset (aresetn low, synchronous) empties the pipeline, clears the ramp, restores defaults.
`default_nettype none

module diff_drive_ramp_brake_controller_unit #(
    parameter int PWM_MAX = 255
) (
    input  wire  logic                                aclk,
    input  wire  logic                                aresetn,
    // Input items.
    input  wire  logic                                s_tvalid,
    output logic                                      s_tready,
    // s_tdata fields from bit 0: gear[1:0], safety_on[2], steer_angle[10:3],
    // power_request[17:11], echo_us[32:18], zero padding[39:33].
    input  wire  logic [ddrbc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // Result items.
    output logic                                      m_tvalid,
    input  wire  logic                                m_tready,
    // m_tdata fields from bit 0: left_pwm[7:0], right_pwm[15:8], bridge_mode[17:16],
    // emergency[18], distance_centi_cm[35:19], zero padding[39:36].
    output logic [ddrbc_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // Configuration writes.
    input  wire  logic                                cfg_valid,
    output logic                                      cfg_ready,
    input  wire  logic [ddrbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  logic [ddrbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ddrbc_pkg::*;

    // Width of the ramp state and of the coefficient for the steering scale.
    localparam int PW  = $clog2(PWM_MAX + 1);
    localparam int CK  = PW + 7;
    localparam int SW  = ((PW > STEP_W) ? PW : STEP_W) + 1;
    localparam int XW  = (PW > DUTY_W) ? PW : DUTY_W;
    localparam int MW  = PW + CK;
    localparam int NUM_POWER = 1 << POWER_W;

    // Configuration registers.
    logic [STOP_W-1:0] stop_reg;
    logic [STEP_W-1:0] accel_reg;
    logic [STEP_W-1:0] brake_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_reg  <= STOP_RESET;
            accel_reg <= ACCEL_RESET;
            brake_reg <= BRAKE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STOP_DISTANCE: stop_reg  <= cfg_data[STOP_W-1:0];
                REG_ACCEL_STEP:    accel_reg <= cfg_data[STEP_W-1:0];
                REG_BRAKE_STEP:    brake_reg <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Constant table of the drive target power*PWM_MAX/100, saturated at PWM_MAX.
    logic [PW-1:0] tgt_tab [NUM_POWER];
    for (genvar gi = 0; gi < NUM_POWER; gi++) begin : g_tgt
        localparam int unsigned TV = (gi * PWM_MAX) / 100;
        assign tgt_tab[gi] = (TV > PWM_MAX) ? PW'(PWM_MAX) : PW'(TV);
    end

    // Constant table of ceil((90-mag)*2^CK/90); a straight-ahead angle needs no scaling.
    logic [CK-1:0] coef_tab [ANGLE_MAX + 1];
    for (genvar gj = 0; gj <= ANGLE_MAX; gj++) begin : g_coef
        localparam longint unsigned CV =
            ((longint'(ANGLE_MAX - gj) << CK) + longint'(ANGLE_MAX - 1)) / ANGLE_MAX;
        assign coef_tab[gj] = (gj == 0) ? '0 : CK'(CV);
    end

    // Pipeline handshake: each stage moves when the one after it has room.
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic adv_out, adv_s2;

    assign adv_out  = !m_valid_reg || m_tready;
    assign adv_s2   = !s2_valid_reg || adv_out;
    assign s_tready = !s1_valid_reg || adv_s2;
    assign m_tvalid = m_valid_reg;

    // Unpack the input item.
    logic [GEAR_W-1:0]         in_gear;
    logic                      in_safety;
    logic signed [ANGLE_W-1:0] in_angle;
    logic [POWER_W-1:0]        in_power;
    logic [ECHO_W-1:0]         in_echo;

    assign in_gear   = s_tdata[1:0];
    assign in_safety = s_tdata[2];
    assign in_angle  = s_tdata[10:3];
    assign in_power  = s_tdata[17:11];
    assign in_echo   = s_tdata[32:18];

    // Front end: echo timeout, obstacle test, echo/10 and the saturated angle magnitude.
    logic                  in_timeout;
    logic [18:0]           echo_x17;
    logic [18:0]           stop_x1000;
    logic                  in_obstacle;
    logic [2*ECHO_W-1:0]   q_prod;
    logic [QUOT_W-1:0]     in_quot;
    logic [15:0]           rem_full;
    logic [MAG_W-1:0]      in_mag;
    logic                  ang_hi, ang_lo;

    assign in_timeout  = (in_echo == '0) || (in_echo > ECHO_LIMIT_US);
    assign echo_x17    = {in_echo, 4'b0000} + 19'(in_echo);
    assign stop_x1000  = 19'(stop_reg) * 19'd1000;
    assign in_obstacle = in_timeout ? (TIMEOUT_CM < 10'(stop_reg)) : (echo_x17 < stop_x1000);
    assign q_prod      = (2*ECHO_W)'(in_echo) * (2*ECHO_W)'(DIV10_MUL);
    assign in_quot     = q_prod[DIV10_SHIFT +: QUOT_W];
    assign rem_full    = 16'(in_echo) - ({in_quot, 3'b000} + {3'b000, in_quot, 1'b0});

    assign ang_hi = in_angle > 8'sd90;
    assign ang_lo = in_angle < -8'sd90;
    always_comb begin
        if (ang_hi || ang_lo) begin
            in_mag = MAG_W'(ANGLE_MAX);
        end else if (in_angle < 0) begin
            in_mag = MAG_W'(-in_angle);
        end else begin
            in_mag = MAG_W'(in_angle);
        end
    end

    // Stage 1 registers.
    logic [GEAR_W-1:0] s1_gear_reg;
    logic              s1_safety_reg;
    logic              s1_obstacle_reg;
    logic              s1_timeout_reg;
    logic [PW-1:0]     s1_target_reg;
    logic [QUOT_W-1:0] s1_quot_reg;
    logic [3:0]        s1_rem_reg;
    logic [CK-1:0]     s1_coef_reg;
    logic              s1_pos_reg;
    logic              s1_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_gear_reg     <= in_gear;
            s1_safety_reg   <= in_safety;
            s1_obstacle_reg <= in_obstacle;
            s1_timeout_reg  <= in_timeout;
            s1_target_reg   <= tgt_tab[in_power];
            s1_quot_reg     <= in_quot;
            s1_rem_reg      <= rem_full[3:0];
            s1_coef_reg     <= coef_tab[in_mag];
            s1_pos_reg      <= in_angle > 0;
            s1_neg_reg      <= in_angle < 0;
        end
    end

    // Ramp: brake, coast, jump or step toward the target and clamp to 0..PWM_MAX.
    logic [PW-1:0]     ramped_reg, ramped_next;
    logic [MODE_W-1:0] mode_next;
    logic              emerg_next;
    logic [SW-1:0]     ramp_up, ramp_down;
    logic              down_floor;
    logic [DIST_W-1:0] dist_next;

    assign ramp_up    = SW'(ramped_reg) + SW'(accel_reg);
    assign ramp_down  = SW'(ramped_reg) - SW'(brake_reg);
    assign down_floor = SW'(ramped_reg) < SW'(brake_reg);
    assign emerg_next = s1_safety_reg && s1_obstacle_reg &&
                        ((s1_gear_reg == GEAR_DRIVE) || (s1_gear_reg == GEAR_SPORT));

    always_comb begin
        ramped_next = ramped_reg;
        mode_next   = MODE_FORWARD;
        if (emerg_next) begin
            ramped_next = '0;
            mode_next   = MODE_BRAKE;
        end else if (s1_gear_reg == GEAR_NEUTRAL) begin
            ramped_next = '0;
            mode_next   = MODE_COAST;
        end else if (s1_gear_reg == GEAR_SPORT) begin
            ramped_next = s1_target_reg;
        end else begin
            if (ramped_reg < s1_target_reg) begin
                ramped_next = (ramp_up > SW'(PWM_MAX)) ? PW'(PWM_MAX) : ramp_up[PW-1:0];
            end else if (ramped_reg > s1_target_reg) begin
                ramped_next = down_floor ? '0 : ramp_down[PW-1:0];
            end
            if (s1_gear_reg == GEAR_REVERSE) begin
                mode_next = MODE_REVERSE;
            end
        end
    end

    // Distance in hundredths of a cm: 17*(echo/10) plus the remainder's share.
    assign dist_next = s1_timeout_reg ? TIMEOUT_CENTI_CM :
                       ({s1_quot_reg, 4'b0000} + DIST_W'(s1_quot_reg) +
                        DIST_W'(dist_frac(s1_rem_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramped_reg <= '0;
        end else if (s1_valid_reg && adv_s2) begin
            ramped_reg <= ramped_next;
        end
    end

    // Stage 2 registers.
    logic [PW-1:0]     s2_power_reg;
    logic [CK-1:0]     s2_coef_reg;
    logic              s2_scale_left_reg;
    logic              s2_scale_right_reg;
    logic [MODE_W-1:0] s2_mode_reg;
    logic              s2_emerg_reg;
    logic [DIST_W-1:0] s2_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv_s2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && adv_s2) begin
            s2_power_reg       <= ramped_next;
            s2_coef_reg        <= s1_coef_reg;
            s2_scale_left_reg  <= s1_neg_reg;
            s2_scale_right_reg <= s1_pos_reg;
            s2_mode_reg        <= mode_next;
            s2_emerg_reg       <= emerg_next;
            s2_dist_reg        <= dist_next;
        end
    end

    // Inner wheel scale: power*(90-|angle|)/90 as one multiply by a reciprocal.
    logic [MW-1:0] scale_prod;
    logic [PW-1:0] scaled;
    logic [XW-1:0] left_x, right_x;

    assign scale_prod = MW'(s2_power_reg) * MW'(s2_coef_reg);
    assign scaled     = scale_prod[MW-1:CK];
    assign left_x     = XW'(s2_scale_left_reg ? scaled : s2_power_reg);
    assign right_x    = XW'(s2_scale_right_reg ? scaled : s2_power_reg);

    // Output register.
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv_out) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && adv_out) begin
            m_tdata_reg <= {4'b0000, s2_dist_reg, s2_emerg_reg, s2_mode_reg,
                            right_x[DUTY_W-1:0], left_x[DUTY_W-1:0]};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

`default_nettype wire
